[sv/thtr_pkg.sv]
`timescale 1ns / 1ps

package thtr_pkg;

    // Field widths of the channels and registers.
    localparam int VALUE_W   = 8;
    localparam int INDEX_W   = 13;
    localparam int STATUS_W  = 2;
    localparam int LEN_W     = 14;
    localparam int LIMIT_W   = 20;
    localparam int WAIT_W    = LIMIT_W + 1;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = LIMIT_W;

    // Longest track that a transfer may cover.
    localparam logic [LEN_W-1:0] TRACK_MAX = LEN_W'(8192);

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_LENGTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_LIMIT = CFG_IDX_W'(1);

    // Register values after reset.
    localparam logic [LEN_W-1:0]   TRACK_LENGTH_RST  = LEN_W'(8192);
    localparam logic [LIMIT_W-1:0] TIMEOUT_LIMIT_RST = LIMIT_W'(1000000);

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK      = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] STATUS_CANCEL  = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] STATUS_EXPIRED = STATUS_W'(2);

    // Fill levels of the three-sample window.
    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_ONE  = 2'd1;
    localparam logic [1:0] HELD_TWO  = 2'd2;

    typedef struct packed {
        logic               start_req;
        logic               line_level;
        logic [VALUE_W-1:0] port_value;
        logic               cancel;
    } tick_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  byte_value;
        logic [INDEX_W-1:0]  byte_index;
        logic                last;
        logic [STATUS_W-1:0] status;
    } result_t;

    typedef struct packed {
        logic [LEN_W-1:0]   track_length;
        logic [LIMIT_W-1:0] timeout_limit;
    } cfg_t;

endpackage

[sv/thtr_if.sv]
`timescale 1ns / 1ps

// Channel carrying one pin-sampling tick.
interface thtr_tick_if
    import thtr_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               start_req;
    logic               line_level;
    logic [VALUE_W-1:0] port_value;
    logic               cancel;

    modport source (output valid, output start_req, output line_level,
                    output port_value, output cancel, input ready);
    modport sink   (input valid, input start_req, input line_level,
                    input port_value, input cancel, output ready);
endinterface

// Channel carrying one received byte or a timeout result.
interface thtr_result_if
    import thtr_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [VALUE_W-1:0]  byte_value;
    logic [INDEX_W-1:0]  byte_index;
    logic                last;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output byte_value, output byte_index,
                    output last, output status, input ready);
    modport sink   (input valid, input byte_value, input byte_index,
                    input last, input status, output ready);
endinterface

[sv/thtr_engine.sv]
`timescale 1ns / 1ps

module thtr_engine
    import thtr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  tick_t   tick_in,
    input  cfg_t    cfg,
    output logic    emit,
    output result_t res
);

    logic                busy_reg, busy_next;
    logic                sampling_reg, sampling_next;
    logic [INDEX_W-1:0]  position_reg, position_next;
    logic [WAIT_W-1:0]   wait_count_reg, wait_count_next;
    logic [VALUE_W-1:0]  older_reg, older_next;
    logic [VALUE_W-1:0]  newer_reg, newer_next;
    logic [1:0]          held_reg, held_next;
    logic                cancel_seen_reg, cancel_seen_next;

    logic [LEN_W-1:0]    eff_length;
    logic [LEN_W-1:0]    position_plus;
    logic                final_byte;

    // Clamp the track length to the range one transfer may cover.
    always_comb
    begin
        if (cfg.track_length == '0)
        begin
            eff_length = LEN_W'(1);
        end
        else if (cfg.track_length > TRACK_MAX)
        begin
            eff_length = TRACK_MAX;
        end
        else
        begin
            eff_length = cfg.track_length;
        end
    end

    assign position_plus = {1'b0, position_reg} + LEN_W'(1);
    assign final_byte    = (position_plus >= eff_length);

    // Next state and the result of the tick in the input register.
    always_comb
    begin
        busy_next        = busy_reg;
        sampling_next    = sampling_reg;
        position_next    = position_reg;
        wait_count_next  = wait_count_reg;
        older_next       = older_reg;
        newer_next       = newer_reg;
        held_next        = held_reg;
        cancel_seen_next = cancel_seen_reg;
        emit             = 1'b0;
        res.byte_value   = tick_in.port_value;
        res.byte_index   = position_reg;
        res.last         = 1'b0;
        res.status       = STATUS_OK;

        if (step)
        begin
            if (!busy_reg)
            begin
                if (tick_in.start_req)
                begin
                    busy_next        = 1'b1;
                    sampling_next    = 1'b0;
                    position_next    = '0;
                    wait_count_next  = '0;
                    held_next        = HELD_NONE;
                    cancel_seen_next = 1'b0;
                end
            end
            else
            begin
                cancel_seen_next = cancel_seen_reg | tick_in.cancel;

                if (!sampling_reg)
                begin
                    // Waiting for the line to reach the level of this byte.
                    if (tick_in.line_level == position_reg[0])
                    begin
                        sampling_next = 1'b1;
                        older_next    = tick_in.port_value;
                        held_next     = HELD_ONE;
                    end
                    else if (wait_count_reg > {1'b0, cfg.timeout_limit})
                    begin
                        emit           = 1'b1;
                        res.byte_value = '0;
                        res.last       = 1'b1;
                        res.status     = STATUS_EXPIRED;
                        busy_next      = 1'b0;
                    end
                    else
                    begin
                        wait_count_next = wait_count_reg + WAIT_W'(1);
                    end
                end
                else if (held_reg != HELD_TWO)
                begin
                    newer_next = tick_in.port_value;
                    held_next  = HELD_TWO;
                end
                else if (older_reg == newer_reg && newer_reg == tick_in.port_value)
                begin
                    // Three equal samples in a row: the byte is stable.
                    emit            = 1'b1;
                    res.last        = final_byte;
                    res.status      = (final_byte && cancel_seen_next) ?
                                      STATUS_CANCEL : STATUS_OK;
                    sampling_next   = 1'b0;
                    held_next       = HELD_NONE;
                    wait_count_next = '0;
                    if (final_byte)
                    begin
                        busy_next = 1'b0;
                    end
                    else
                    begin
                        position_next = position_reg + INDEX_W'(1);
                    end
                end
                else
                begin
                    older_next = newer_reg;
                    newer_next = tick_in.port_value;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            sampling_reg    <= 1'b0;
            position_reg    <= '0;
            wait_count_reg  <= '0;
            older_reg       <= '0;
            newer_reg       <= '0;
            held_reg        <= HELD_NONE;
            cancel_seen_reg <= 1'b0;
        end
        else
        begin
            busy_reg        <= busy_next;
            sampling_reg    <= sampling_next;
            position_reg    <= position_next;
            wait_count_reg  <= wait_count_next;
            older_reg       <= older_next;
            newer_reg       <= newer_next;
            held_reg        <= held_next;
            cancel_seen_reg <= cancel_seen_next;
        end
    end

endmodule

[sv/toggle_handshake_track_reader_core.sv]
`timescale 1ns / 1ps

// Channel   Direction  Contents
// tick      in         start_req, line_level, port_value, cancel
// result    out        byte_value, byte_index, last, status
// cfg_*     in         write enable, register index, write data
//
// A tick accepted at one edge waits in the input register until the output
// register can take a result; its result, if any, is then registered there.
// One tick is accepted per cycle as long as the output register is free or
// being drained; while a result waits, the held tick stays put and the
// input closes until the output register frees up.
// Reset clears the control state and loads the register defaults.

module toggle_handshake_track_reader_core
    import thtr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    thtr_tick_if.sink             tick,
    thtr_result_if.source         result
);

    cfg_t    cfg_reg;
    logic    in_valid_reg;
    tick_t   in_data_reg;
    logic    out_valid_reg;
    result_t out_data_reg;
    logic    step;
    logic    emit;
    result_t res;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.track_length  <= TRACK_LENGTH_RST;
            cfg_reg.timeout_limit <= TIMEOUT_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TRACK_LENGTH:  cfg_reg.track_length  <= cfg_wdata[LEN_W-1:0];
                REG_TIMEOUT_LIMIT: cfg_reg.timeout_limit <= cfg_wdata[LIMIT_W-1:0];
                default:           ;
            endcase
        end
    end

    // The held tick is processed once the output register can take a result.
    assign step       = in_valid_reg && (!out_valid_reg || result.ready);
    assign tick.ready = !in_valid_reg || step;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (tick.ready)
        begin
            in_valid_reg <= tick.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            in_data_reg.start_req  <= tick.start_req;
            in_data_reg.line_level <= tick.line_level;
            in_data_reg.port_value <= tick.port_value;
            in_data_reg.cancel     <= tick.cancel;
        end
    end

    thtr_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .tick_in (in_data_reg),
        .cfg     (cfg_reg),
        .emit    (emit),
        .res     (res)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            out_data_reg <= res;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.byte_value = out_data_reg.byte_value;
    assign result.byte_index = out_data_reg.byte_index;
    assign result.last       = out_data_reg.last;
    assign result.status     = out_data_reg.status;

endmodule
